// ----- rtl/jbow_pkg.sv -----
// package: shared constants, state type and wheel clamp/deadband function for the omni drive
`default_nettype none
package jbow_pkg;

  // channel store
  localparam int unsigned CHANNELS = 16;
  localparam int unsigned CH_W     = $clog2(CHANNELS);

  // byte code ranges
  localparam logic [7:0] ADDR_BASE = 8'd201;
  localparam logic [7:0] BTN_BASE  = 8'd231;
  localparam logic [7:0] BTN_END   = 8'd247;
  localparam logic [7:0] TERM_BYTE = 8'd255;
  localparam logic [7:0] CH0_RESET = 8'd100;

  // configuration register indexes
  localparam logic [1:0] REG_FULL_SCALE = 2'd0;
  localparam logic [1:0] REG_AXIS_SPAN  = 2'd1;
  localparam logic [1:0] REG_DEAD_BAND  = 2'd2;

  // reset values of the configuration registers
  localparam logic [7:0] FULL_SCALE_RST = 8'd200;
  localparam logic [7:0] AXIS_SPAN_RST  = 8'd120;
  localparam logic [7:0] DEAD_BAND_RST  = 8'd20;

  // divider: dividend is v * 2s, at most 17 bits
  localparam int unsigned DVD_W     = 17;
  localparam int unsigned DIV_STEPS = DVD_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  // signed widths for the axes and the mix
  localparam int unsigned AXW = 20;
  localparam int unsigned MXW = 22;
  localparam int unsigned CLW = 10;

  // wheel direction codes
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd2;

  localparam logic signed [CLW-1:0] SPEED_MAX = 10'sd255;
  localparam logic signed [CLW-1:0] SPEED_MIN = -10'sd255;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_MIX,
    ST_OUT
  } state_e;

  // result of one wheel evaluation
  typedef struct packed {
    logic [7:0] speed;
    logic [1:0] dir;
    logic       upd;
  } wheel_t;

  // clamp to +-255, then deadband that keeps the old direction
  function automatic wheel_t wheel_calc(logic signed [MXW-1:0] w, logic [7:0] db);
    logic signed [CLW-1:0] cw;
    logic signed [CLW-1:0] dbs;
    logic signed [CLW-1:0] ndb;
    wheel_t r;
    if (w > MXW'(SPEED_MAX)) begin
      cw = SPEED_MAX;
    end else if (w < MXW'(SPEED_MIN)) begin
      cw = SPEED_MIN;
    end else begin
      cw = w[CLW-1:0];
    end
    dbs = signed'({2'b00, db});
    ndb = -dbs;
    r.speed = 8'd0;
    r.dir   = DIR_NONE;
    r.upd   = 1'b0;
    if (cw < ndb) begin
      r.speed = 8'((-cw));
      r.dir   = DIR_REV;
      r.upd   = 1'b1;
    end else if (cw > dbs) begin
      r.speed = cw[7:0];
      r.dir   = DIR_FWD;
      r.upd   = 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/joystick_byte_to_omni_wheel_drive_top.sv -----
// top level: joystick byte decoder, shared divider sequencer and omni-wheel mixer
//
// Usage: one serial byte per transfer enters on s_axis (tdata = rx_byte).
// Address bytes select a channel, button bytes also give a one-shot pulse,
// data bytes land in the selected channel. After every byte the block
// rescales channels 0..3 to joystick axes, mixes three wheel speeds and
// returns one result transfer on m_axis.
// Sequence: the block loads each of the four channels in turn into one
// shared 17-bit divider and runs 17 restoring-division steps on it, then
// does the axis mix and the wheel stage, and registers the result.
// Input: s_axis_tready is high only while the sequencer is idle, so a byte is
// taken only once the previous one is through; the idle block takes a byte
// even while the previous result still waits in the output register.
// Stall: if m_axis_tready is low the result holds in the output register;
// a following byte is computed and then waits until that register frees.
// Reset (rst_ni low): channel 0 = 100, others 0, no address selected,
// directions 0, registers at 200 / 120 / 20, no result pending.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i (0 full scale,
// 1 axis span, 2 deadband); user must write while idle, the block does not check.
`default_nettype none
module joystick_byte_to_omni_wheel_drive_top
  import jbow_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata    // [7:0] front_speed, [9:8] front_dir,
                                           // [17:10] right_speed, [19:18] right_dir,
                                           // [27:20] left_speed, [29:28] left_dir,
                                           // [45:30] button_pulse, [47:46] zero
);

  // configuration registers
  logic [7:0] full_scale_q, axis_span_q, dead_band_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q <= FULL_SCALE_RST;
      axis_span_q  <= AXIS_SPAN_RST;
      dead_band_q  <= DEAD_BAND_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FULL_SCALE: full_scale_q <= cfg_data_i;
        REG_AXIS_SPAN:  axis_span_q  <= cfg_data_i;
        REG_DEAD_BAND:  dead_band_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [7:0] divisor;
  assign divisor = (full_scale_q == 8'd0) ? 8'd1 : full_scale_q;

  // sequencer state and control
  state_e state_q, state_d;
  logic [1:0]       chan_q;
  logic [CNT_W-1:0] cnt_q;
  logic             out_valid_q;
  logic             in_xfer, out_xfer, out_free, last_step;
  logic             ctl_load, ctl_div, ctl_mix, ctl_out;

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign out_xfer  = m_axis_tvalid && m_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign last_step = (cnt_q == CNT_W'(DIV_STEPS - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (s_axis_tvalid) state_d = ST_LOAD;
      ST_LOAD: state_d = ST_DIV;
      ST_DIV: begin
        if (last_step) state_d = (chan_q == 2'd3) ? ST_MIX : ST_LOAD;
      end
      ST_MIX:  state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    ctl_load      = 1'b0;
    ctl_div       = 1'b0;
    ctl_mix       = 1'b0;
    ctl_out       = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_LOAD: ctl_load      = 1'b1;
      ST_DIV:  ctl_div       = 1'b1;
      ST_MIX:  ctl_mix       = 1'b1;
      ST_OUT:  ctl_out       = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      chan_q  <= 2'd0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (in_xfer) chan_q <= 2'd0;
      else if (ctl_div && last_step) chan_q <= chan_q + 2'd1;
      if (ctl_load) cnt_q <= '0;
      else if (ctl_div) cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  // byte decode: address, button pulse, channel write
  logic [7:0]       addr_q;
  logic [7:0]       store_q [CHANNELS];
  logic [15:0]      pulse_q;
  logic [7:0]       ch_off;
  logic             is_addr, is_btn, is_data, ch_ok;

  assign is_addr = (s_axis_tdata >= ADDR_BASE) && (s_axis_tdata != TERM_BYTE);
  assign is_btn  = (s_axis_tdata >= BTN_BASE) && (s_axis_tdata < BTN_END);
  assign is_data = (s_axis_tdata < ADDR_BASE);
  assign ch_off  = addr_q - ADDR_BASE;
  assign ch_ok   = (addr_q >= ADDR_BASE) && (ch_off < 8'(CHANNELS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= TERM_BYTE;
      for (int i = 0; i < CHANNELS; i++) begin
        store_q[i] <= (i == 0) ? CH0_RESET : 8'd0;
      end
    end else if (in_xfer) begin
      if (is_addr) begin
        addr_q <= s_axis_tdata;
      end else if (is_data && ch_ok) begin
        store_q[ch_off[CH_W-1:0]] <= s_axis_tdata;
      end
    end
  end

  // pulse rides along with the item
  logic [7:0] btn_off;
  assign btn_off = s_axis_tdata - BTN_BASE;

  always_ff @(posedge clk_i) begin
    if (in_xfer) pulse_q <= is_btn ? (16'd1 << btn_off[3:0]) : 16'd0;
  end

  // shared restoring divider: (v * 2s) / f, one quotient bit per cycle
  logic [7:0]        chan_val;
  logic [DVD_W-1:0]  product;
  logic [DVD_W-1:0]  dvd_q;
  logic [7:0]        rem_q;
  logic [8:0]        rem_sh;
  logic [8:0]        rem_sub;
  logic              q_bit;
  logic [DVD_W-1:0]  quot_n;

  assign chan_val = store_q[CH_W'(chan_q)];
  assign product  = DVD_W'(chan_val) * DVD_W'({axis_span_q, 1'b0});
  assign rem_sh   = {rem_q, dvd_q[DVD_W-1]};
  assign rem_sub  = rem_sh - {1'b0, divisor};
  assign q_bit    = (rem_sh >= {1'b0, divisor});
  assign quot_n   = {dvd_q[DVD_W-2:0], q_bit};

  always_ff @(posedge clk_i) begin
    if (ctl_load) begin
      dvd_q <= product;
      rem_q <= 8'd0;
    end else if (ctl_div) begin
      dvd_q <= quot_n;
      rem_q <= q_bit ? rem_sub[7:0] : rem_sh[7:0];
    end
  end

  // axis store: even channels q - s, odd channels s - q
  logic signed [AXW-1:0] axes_q [4];
  logic signed [AXW-1:0] q_ext, s_ext;

  assign q_ext = signed'({{(AXW-DVD_W){1'b0}}, quot_n});
  assign s_ext = signed'({{(AXW-8){1'b0}}, axis_span_q});

  always_ff @(posedge clk_i) begin
    if (ctl_div && last_step) begin
      axes_q[chan_q] <= chan_q[0] ? (s_ext - q_ext) : (q_ext - s_ext);
    end
  end

  // mix stage one: m = (x2 + y2) / 2 toward zero
  logic signed [MXW-1:0] m_q, m_sum, m_rnd;
  assign m_sum = MXW'(axes_q[3]) + MXW'(axes_q[2]);
  // add one to a negative sum so the shift truncates toward zero
  assign m_rnd = m_sum + MXW'(signed'({1'b0, m_sum[MXW-1]}));

  always_ff @(posedge clk_i) begin
    if (ctl_mix) m_q <= m_rnd >>> 1;
  end

  // mix stage two: wheels, clamp and deadband
  logic signed [MXW-1:0] y1_e, x1_e, w_front, w_right, w_left, w_lsum;
  wheel_t wf, wr, wl;
  logic [1:0] dir_q [3];
  logic [1:0] dir_f, dir_r, dir_l;
  logic [47:0] out_data_q;

  assign y1_e    = MXW'(axes_q[0]);
  assign x1_e    = MXW'(axes_q[1]);
  assign w_front = m_q - x1_e - y1_e;
  assign w_right = m_q + x1_e - y1_e;
  assign w_lsum  = m_q + y1_e;
  assign w_left  = w_lsum <<< 1;
  assign wf      = wheel_calc(w_front, dead_band_q);
  assign wr      = wheel_calc(w_right, dead_band_q);
  assign wl      = wheel_calc(w_left, dead_band_q);
  assign dir_f   = wf.upd ? wf.dir : dir_q[0];
  assign dir_r   = wr.upd ? wr.dir : dir_q[1];
  assign dir_l   = wl.upd ? wl.dir : dir_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q[0]    <= DIR_NONE;
      dir_q[1]    <= DIR_NONE;
      dir_q[2]    <= DIR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_out) begin
        dir_q[0]    <= dir_f;
        dir_q[1]    <= dir_r;
        dir_q[2]    <= dir_l;
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (ctl_out) begin
      out_data_q <= {2'b00, pulse_q, dir_l, wl.speed, dir_r, wr.speed, dir_f, wf.speed};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // checks
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (cnt_q < CNT_W'(DIV_STEPS)))
    else $error("divider step count out of range");

  a_start_chan0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_LOAD) && (chan_q == 2'd0))
    else $error("item did not start at channel zero");

  a_dir_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[9:8] != 2'b11) && (m_axis_tdata[19:18] != 2'b11)
                      && (m_axis_tdata[29:28] != 2'b11))
    else $error("invalid wheel direction code");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("pending result dropped");

endmodule
`default_nettype wire

// ----- verif/joystick_byte_to_omni_wheel_drive_top_test.sv -----
// testbench: streams joystick bytes into the omni drive and checks every wheel result
`timescale 1ns / 100ps
module joystick_byte_to_omni_wheel_drive_top_test
  import jbow_pkg::*;
();

  localparam logic [1:0] REG_SPARE      = 2'd3;
  localparam int         WATCHDOG_LIMIT = 4000;
  localparam int         SETTLE_CYCLES  = 100;
  localparam int         LONG_STALL     = 500;
  localparam int         STALL_AT       = 100;

  // expected result, front_speed in the lowest bits as on m_axis_tdata
  typedef struct packed {
    logic [15:0] button_pulse;
    logic [1:0]  left_dir;
    logic [7:0]  left_speed;
    logic [1:0]  right_dir;
    logic [7:0]  right_speed;
    logic [1:0]  front_dir;
    logic [7:0]  front_speed;
  } drive_res_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = '0;
  logic [7:0]  cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] rx_byte
  logic        m_axis_tready = 1'b0;
  wire logic        s_axis_tready;
  wire logic        m_axis_tvalid;
  wire logic [47:0] m_axis_tdata;   // [7:0] front_speed, [9:8] front_dir,
                                    // [17:10] right_speed, [19:18] right_dir,
                                    // [27:20] left_speed, [29:28] left_dir,
                                    // [45:30] button_pulse, [47:46] zero

  joystick_byte_to_omni_wheel_drive_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the block state and registers
  logic [7:0] chan_m [CHANNELS];
  logic [7:0] addr_m;
  logic [1:0] dir_m [3];
  logic [7:0] full_scale_m;
  logic [7:0] span_m;
  logic [7:0] dead_band_m;

  logic [7:0] pend_bytes [$];
  drive_res_t exp_drive [$];

  bit         drv_valid   = 1'b0;
  logic [7:0] drv_data    = '0;
  int         in_gap      = 0;
  int         in_gap_max  = 7;
  int         out_gap     = 0;
  int         out_gap_max = 7;
  int         stall_left  = 0;
  bit         stall_done  = 1'b0;
  bit         byte_taken  = 1'b0;
  bit         res_taken   = 1'b0;
  int         res_count   = 0;
  int         err_count   = 0;
  int         idle_cycles = 0;

  task automatic init_model();
    for (int i = 0; i < CHANNELS; i++) chan_m[i] = 8'd0;
    chan_m[0] = CH0_RESET;
    addr_m = TERM_BYTE;
    for (int i = 0; i < 3; i++) dir_m[i] = DIR_NONE;
    full_scale_m = FULL_SCALE_RST;
    span_m       = AXIS_SPAN_RST;
    dead_band_m  = DEAD_BAND_RST;
  endtask

  // raw channel value to (v * 2s) / f, full scale of zero counts as one
  function automatic int axis_scale(logic [7:0] v);
    int f;
    f = (full_scale_m == 8'd0) ? 1 : int'(full_scale_m);
    return (int'(v) * 2 * int'(span_m)) / f;
  endfunction

  // clamp and deadband; direction only moves outside the band
  function automatic logic [7:0] wheel_drive(int w, int idx);
    int db;
    db = int'(dead_band_m);
    if (w > 255) w = 255;
    if (w < -255) w = -255;
    if (w < -db) begin
      dir_m[idx] = DIR_REV;
      return 8'(-w);
    end
    if (w > db) begin
      dir_m[idx] = DIR_FWD;
      return 8'(w);
    end
    return 8'd0;
  endfunction

  // decode one byte, update the shadow state, mix the wheel speeds
  function automatic drive_res_t predict_drive(logic [7:0] b);
    drive_res_t r;
    int s, y1, x1, y2, x2, m, ch;
    r = '0;
    s = int'(span_m);
    if (b >= ADDR_BASE && b != TERM_BYTE) begin
      addr_m = b;
      if (b >= BTN_BASE && b < BTN_END) r.button_pulse = 16'd1 << (b - BTN_BASE);
    end else if (b < ADDR_BASE) begin
      ch = int'(addr_m) - int'(ADDR_BASE);
      if (addr_m >= ADDR_BASE && ch < CHANNELS) chan_m[ch] = b;
    end
    y1 = axis_scale(chan_m[0]) - s;
    x1 = s - axis_scale(chan_m[1]);
    y2 = axis_scale(chan_m[2]) - s;
    x2 = s - axis_scale(chan_m[3]);
    m  = (x2 + y2) / 2;
    r.front_speed = wheel_drive(m - x1 - y1, 0);
    r.front_dir   = dir_m[0];
    r.right_speed = wheel_drive(m + x1 - y1, 1);
    r.right_dir   = dir_m[1];
    r.left_speed  = wheel_drive((m + y1) * 2, 2);
    r.left_dir    = dir_m[2];
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // register write while the block is idle
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      REG_FULL_SCALE: full_scale_m = val;
      REG_AXIS_SPAN:  span_m       = val;
      REG_DEAD_BAND:  dead_band_m  = val;
      default: ;
    endcase
  endtask

  // mostly address-then-data pairs on the joystick channels, plus noise
  task automatic queue_random(input int n);
    int k, pick;
    k = 0;
    while (k < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        pend_bytes.push_back(8'(ADDR_BASE + $urandom_range(0, 3)));
        pend_bytes.push_back(8'($urandom_range(0, 200)));
        k += 2;
      end else if (pick < 70) begin
        pend_bytes.push_back(8'(BTN_BASE + $urandom_range(0, 15)));
        k++;
      end else if (pick < 82) begin
        pend_bytes.push_back(8'($urandom_range(201, 254)));
        pend_bytes.push_back(8'($urandom_range(0, 200)));
        k += 2;
      end else if (pick < 95) begin
        pend_bytes.push_back(8'($urandom_range(0, 255)));
        k++;
      end else begin
        pend_bytes.push_back(TERM_BYTE);
        k++;
      end
    end
  endtask

  // wait for all bytes and results, then let the sequencer settle
  task automatic drain();
    while (pend_bytes.size() != 0 || drv_valid || exp_drive.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // byte driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      drv_valid = 1'b0;
      in_gap    = $urandom_range(0, in_gap_max);
    end else begin
      if (byte_taken) begin
        byte_taken = 1'b0;
        drv_valid  = 1'b0;
        void'(pend_bytes.pop_front());
        in_gap = $urandom_range(0, in_gap_max);
      end
      if (!drv_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pend_bytes.size() != 0) begin
          drv_valid = 1'b1;
          drv_data  = pend_bytes[0];
        end
      end
    end
    s_axis_tvalid <= drv_valid;
    s_axis_tdata  <= drv_data;
  end

  // result receiver with random gaps and one long hold-off
  always @(negedge clk_i) begin : result_sink
    bit rdy;
    rdy = 1'b0;
    if (rst_ni) begin
      if (res_taken) begin
        res_taken = 1'b0;
        out_gap   = $urandom_range(0, out_gap_max);
      end
      if (!stall_done && res_count >= STALL_AT) begin
        stall_done = 1'b1;
        stall_left = LONG_STALL;
      end
      if (stall_left > 0) stall_left--;
      else if (out_gap > 0) out_gap--;
      else rdy = 1'b1;
    end
    m_axis_tready <= rdy;
  end

  // transfer capture, result check and watchdog
  always @(posedge clk_i) begin : transfer_check
    drive_res_t got, want;
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        exp_drive.push_back(predict_drive(s_axis_tdata));
        byte_taken = 1'b1;
        moved = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[45:0];
        res_taken = 1'b1;
        res_count++;
        moved = 1'b1;
        if (exp_drive.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result, expected none actual %h", $time, m_axis_tdata);
        end else begin
          want = exp_drive.pop_front();
          check_field("front_speed", want.front_speed, got.front_speed);
          check_field("front_dir", want.front_dir, got.front_dir);
          check_field("right_speed", want.right_speed, got.right_speed);
          check_field("right_dir", want.right_dir, got.right_dir);
          check_field("left_speed", want.left_speed, got.left_speed);
          check_field("left_dir", want.left_dir, got.left_dir);
          check_field("button_pulse", want.button_pulse, got.button_pulse);
          check_field("tdata pad", 0, m_axis_tdata[47:46]);
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // reset, directed bytes, then random phases over several register settings
  initial begin
    init_model();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // terminator and data before any address, channel writes at the range ends,
    // all button bounds, dropped data on missing channels
    pend_bytes = {TERM_BYTE, 8'd0, 8'd100, 8'd201, 8'd0, 8'd200, 8'd202, 8'd0,
                  8'd203, 8'd200, 8'd204, 8'd0, 8'd230, 8'd231, 8'd246, 8'd247,
                  8'd254, 8'd5, 8'd216, 8'd77, 8'd217, 8'd9, 8'd201, 8'd100, TERM_BYTE};
    drain();

    // extreme settings, long receiver hold-off lands here
    write_reg(REG_FULL_SCALE, 8'd255);
    write_reg(REG_AXIS_SPAN, 8'd255);
    write_reg(REG_DEAD_BAND, 8'd0);
    queue_random(100);
    drain();

    // zero span, widest deadband, write to the spare index
    write_reg(REG_FULL_SCALE, 8'd1);
    write_reg(REG_AXIS_SPAN, 8'd0);
    write_reg(REG_DEAD_BAND, 8'd255);
    write_reg(REG_SPARE, 8'($urandom_range(0, 255)));
    queue_random(80);
    drain();

    // zero full scale, back to back with no idling
    in_gap_max  = 0;
    out_gap_max = 0;
    write_reg(REG_FULL_SCALE, 8'd0);
    write_reg(REG_AXIS_SPAN, 8'd255);
    write_reg(REG_DEAD_BAND, 8'd0);
    queue_random(80);
    drain();

    in_gap_max  = 7;
    out_gap_max = 7;
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_FULL_SCALE, 8'($urandom_range(0, 255)));
      write_reg(REG_AXIS_SPAN, 8'($urandom_range(0, 255)));
      write_reg(REG_DEAD_BAND, ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 40))
                                                             : 8'($urandom_range(0, 255)));
      if (ph == 2) write_reg(REG_SPARE, 8'($urandom_range(0, 255)));
      queue_random(90);
      drain();
    end

    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/jbow_pkg.sv
rtl/joystick_byte_to_omni_wheel_drive_top.sv
verif/joystick_byte_to_omni_wheel_drive_top_test.sv
